>>> rtl/ngba_pkg.sv
// Package with the sizes, codes and types shared by the block allocator files.
`timescale 1ns / 1ps
package ngba_pkg;
    localparam int GROUPS           = 16;
    localparam int BLOCKS_PER_GROUP = 1024;
    localparam int MAX_RUN          = 16;
    localparam int WORD_W           = 16;
    localparam int HALF_W           = WORD_W / 2;
    localparam int WORDS_PER_GROUP  = BLOCKS_PER_GROUP / WORD_W;
    localparam int MAP_WORDS        = GROUPS * WORDS_PER_GROUP;
    localparam int GRP_W            = 4;
    localparam int WIDX_W           = 6;
    localparam int MAP_AW           = 10;
    localparam int CNT_W            = 11;
    localparam int LEN_W            = 5;
    localparam int BLK_W            = 10;
    localparam int TOT_W            = 15;
    localparam int TOTAL_BLOCKS     = GROUPS * BLOCKS_PER_GROUP;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_FRAG    = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_RD, S_LO, S_HI,
        S_SET_RA, S_SET_WA, S_SET_RB, S_SET_WB, S_DONE
    } state_t;

    // Result of one pass over the group counts.
    typedef struct packed {
        logic             done;
        logic             found;
        logic [GRP_W-1:0] group;
    } scan_res_t;

    // Count update after a run has been allocated.
    typedef struct packed {
        logic             valid;
        logic [GRP_W-1:0] group;
        logic [LEN_W-1:0] len;
    } cnt_dec_t;
endpackage

>>> rtl/ngba_ram.sv
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps
module ngba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // A read of addr each cycle, and a write as well when we is high; the read returns the old word.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> rtl/ngba_grp_scan.sv
// Group free counts and the one-group-per-cycle nearest-group search.
`timescale 1ns / 1ps
module ngba_grp_scan (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [ngba_pkg::GRP_W-1:0] pref_group,
    input  logic [ngba_pkg::LEN_W-1:0] run_len,
    input  ngba_pkg::cnt_dec_t         dec,
    output ngba_pkg::scan_res_t        res
);
    import ngba_pkg::*;

    logic [CNT_W-1:0] counts_reg [GROUPS];
    logic [GRP_W-1:0] idx_reg, best_reg;
    logic [GRP_W-1:0] bdist_reg;
    logic             busy_reg, found_reg, done_reg;
    logic [CNT_W-1:0] cnt;
    logic [GRP_W-1:0] gdist;
    logic             qual;

    // Shared compare: one group's count and distance against the best so far.
    always_comb begin
        cnt   = counts_reg[idx_reg];
        gdist = (idx_reg > pref_group) ? idx_reg - pref_group : pref_group - idx_reg;
        qual  = (cnt <= CNT_W'(BLOCKS_PER_GROUP)) && (cnt >= CNT_W'(run_len)) &&
                (!found_reg || gdist < bdist_reg);
    end

    // Scan sequencer and count storage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < GROUPS; g++) begin
                counts_reg[g] <= CNT_W'(BLOCKS_PER_GROUP);
            end
            busy_reg  <= 1'b0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
            idx_reg   <= '0;
            best_reg  <= '0;
            bdist_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                found_reg <= 1'b0;
                idx_reg   <= '0;
            end else if (busy_reg) begin
                if (qual) begin
                    found_reg <= 1'b1;
                    best_reg  <= idx_reg;
                    bdist_reg <= gdist;
                end
                if (idx_reg == GRP_W'(GROUPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (dec.valid) begin
                counts_reg[dec.group] <= counts_reg[dec.group] - CNT_W'(dec.len);
            end
        end
    end

    assign res.done  = done_reg;
    assign res.found = found_reg;
    assign res.group = best_reg;
endmodule

>>> rtl/nearest_group_block_allocator_unit.sv
// Top level of the nearest-group block allocator.
// Usage:
// The s_ channel takes one request beat (start_group, run_length); the m_
// channel returns one result beat (status, group_index, block_index,
// total_free) for each request. One request is handled at a time and
// s_ready is high only while the sequencer is idle.
// Steps: the group scan checks the 16 counts in turn, then each 16-bit word
// of the group's bitmap (up to 64 words per group) is read in S_RD and
// searched one half at a time in S_LO and S_HI; then the run is set in one
// or two words and the result is registered. A bad run length skips these
// steps. After reset the bitmap RAM is cleared one word a cycle, all 1024
// words, before the first request is taken; counts and total return to full.
// A stalled receiver holds the result in the output register; the block
// waits with its next result until that beat is taken.
`timescale 1ns / 1ps
module nearest_group_block_allocator_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ngba_pkg::GRP_W-1:0]  s_start_group,
    input  logic [ngba_pkg::LEN_W-1:0]  s_run_length,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [ngba_pkg::GRP_W-1:0]  m_group_index,
    output logic [ngba_pkg::BLK_W-1:0]  m_block_index,
    output logic [ngba_pkg::TOT_W-1:0]  m_total_free
);
    import ngba_pkg::*;

    state_t            state_reg, state_next;
    logic [MAP_AW-1:0] clr_reg, clr_next;
    logic [GRP_W-1:0]  sg_reg, sg_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [GRP_W-1:0]  grp_reg, grp_next;
    logic [WIDX_W-1:0] word_reg, word_next;
    logic [LEN_W-1:0]  zeros_reg, zeros_next;
    logic [BLK_W-1:0]  first_reg, first_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    status_t           st_reg, st_next;
    logic              mv_reg, mv_next;
    logic [1:0]        ms_reg, ms_next;
    logic [GRP_W-1:0]  mg_reg, mg_next;
    logic [BLK_W-1:0]  mb_reg, mb_next;
    logic [TOT_W-1:0]  mt_reg, mt_next;

    logic              ram_we;
    logic [MAP_AW-1:0] ram_addr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    logic              scan_start;
    scan_res_t         scan_res;
    cnt_dec_t          dec;

    logic [2*WORD_W-1:0] mask;
    logic                span;
    logic [LEN_W-1:0]    z;
    logic                hit;
    logic [BLK_W:0]      pos;
    logic                half_sel;

    ngba_ram #(.WIDTH(WORD_W), .DEPTH(MAP_WORDS)) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    ngba_grp_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (scan_start),
        .pref_group (sg_reg),
        .run_len    (len_reg),
        .dec        (dec),
        .res        (scan_res)
    );

    // Mask of the run across the word that holds its first block and the next.
    always_comb begin
        mask = (2*WORD_W)'({WORD_W{1'b1}}) >> (LEN_W'(WORD_W) - len_reg);
        mask = mask << first_reg[3:0];
        span = ({1'b0, first_reg[3:0]} + len_reg) > LEN_W'(WORD_W);
    end

    // Run search over one half word: eight steps of the zero counter.
    always_comb begin
        half_sel = (state_reg == S_HI);
        z        = zeros_reg;
        hit      = 1'b0;
        pos      = '0;
        for (int j = 0; j < HALF_W; j++) begin
            if (!hit) begin
                if (ram_rdata[{half_sel, 3'(j)}]) begin
                    z = '0;
                end else begin
                    z = z + 1'b1;
                    if (z == len_reg) begin
                        hit = 1'b1;
                        pos = {1'b0, word_reg, half_sel, 3'(j)} + 1'b1 - (BLK_W+1)'(len_reg);
                    end
                end
            end
        end
    end

    // Sequencer: next state, datapath updates and RAM controls.
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        sg_next    = sg_reg;
        len_next   = len_reg;
        grp_next   = grp_reg;
        word_next  = word_reg;
        zeros_next = zeros_reg;
        first_next = first_reg;
        total_next = total_reg;
        st_next    = st_reg;
        mv_next    = mv_reg;
        ms_next    = ms_reg;
        mg_next    = mg_reg;
        mb_next    = mb_reg;
        mt_next    = mt_reg;
        ram_we     = 1'b0;
        ram_addr   = {grp_reg, word_reg};
        ram_wdata  = '0;
        scan_start = 1'b0;
        dec.valid  = 1'b0;
        dec.group  = grp_reg;
        dec.len    = len_reg;
        s_ready    = 1'b0;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == MAP_AW'(MAP_WORDS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    sg_next = s_start_group;
                    len_next = s_run_length;
                    if (s_run_length == '0 || s_run_length > LEN_W'(MAX_RUN)) begin
                        st_next    = ST_NOSPACE;
                        state_next = S_DONE;
                    end else begin
                        scan_start = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (scan_res.done) begin
                    if (scan_res.found) begin
                        grp_next   = scan_res.group;
                        word_next  = '0;
                        zeros_next = '0;
                        state_next = S_RD;
                    end else begin
                        st_next    = ST_NOSPACE;
                        state_next = S_DONE;
                    end
                end
            end
            S_RD: begin
                state_next = S_LO;
            end
            S_LO: begin
                zeros_next = z;
                if (hit) begin
                    first_next = pos[BLK_W-1:0];
                    state_next = S_SET_RA;
                end else begin
                    state_next = S_HI;
                end
            end
            S_HI: begin
                zeros_next = z;
                if (hit) begin
                    first_next = pos[BLK_W-1:0];
                    state_next = S_SET_RA;
                end else if (word_reg == WIDX_W'(WORDS_PER_GROUP - 1)) begin
                    st_next    = ST_FRAG;
                    state_next = S_DONE;
                end else begin
                    word_next  = word_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_SET_RA: begin
                ram_addr   = {grp_reg, first_reg[BLK_W-1:4]};
                state_next = S_SET_WA;
            end
            S_SET_WA: begin
                ram_addr   = {grp_reg, first_reg[BLK_W-1:4]};
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata | mask[WORD_W-1:0];
                state_next = span ? S_SET_RB : S_DONE;
                st_next    = ST_OK;
                dec.valid  = 1'b1;
                total_next = (total_reg >= TOT_W'(len_reg)) ? total_reg - TOT_W'(len_reg) : '0;
            end
            S_SET_RB: begin
                ram_addr   = {grp_reg, first_reg[BLK_W-1:4] + 1'b1};
                state_next = S_SET_WB;
            end
            S_SET_WB: begin
                ram_addr   = {grp_reg, first_reg[BLK_W-1:4] + 1'b1};
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata | mask[2*WORD_W-1:WORD_W];
                state_next = S_DONE;
            end
            S_DONE: begin
                // Load the result beat once the output register is free.
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    ms_next    = st_reg;
                    mg_next    = (st_reg == ST_OK) ? grp_reg : '0;
                    mb_next    = (st_reg == ST_OK) ? first_reg : '0;
                    mt_next    = total_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            total_reg <= TOT_W'(TOTAL_BLOCKS);
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            total_reg <= total_next;
            mv_reg    <= mv_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        sg_reg    <= sg_next;
        len_reg   <= len_next;
        grp_reg   <= grp_next;
        word_reg  <= word_next;
        zeros_reg <= zeros_next;
        first_reg <= first_next;
        st_reg    <= st_next;
        ms_reg    <= ms_next;
        mg_reg    <= mg_next;
        mb_reg    <= mb_next;
        mt_reg    <= mt_next;
    end

    assign m_valid       = mv_reg;
    assign m_status      = ms_reg;
    assign m_group_index = mg_reg;
    assign m_block_index = mb_reg;
    assign m_total_free  = mt_reg;
endmodule

>>> tb/nearest_group_block_allocator_unit_tb.sv
// Testbench for the nearest-group block allocator: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module nearest_group_block_allocator_unit_tb;
    import ngba_pkg::*;

    // Predicted allocator state and the queue of expected result beats.
    class alloc_scoreboard;
        int unsigned grp_free[GROUPS];
        bit          bitmap[GROUPS][BLOCKS_PER_GROUP];
        int unsigned free_blocks;
        status_t     exp_status[$];
        logic [GRP_W-1:0] exp_group[$];
        logic [BLK_W-1:0] exp_block[$];
        logic [TOT_W-1:0] exp_total[$];
        int errors;
        int n_ok, n_nospace, n_frag;

        function void clear_state();
            for (int g = 0; g < GROUPS; g++) begin
                grp_free[g] = BLOCKS_PER_GROUP;
                for (int b = 0; b < BLOCKS_PER_GROUP; b++) bitmap[g][b] = 1'b0;
            end
            free_blocks = TOTAL_BLOCKS;
            errors = 0;
        endfunction

        function void push(status_t st, int unsigned g, int unsigned b);
            exp_status.push_back(st);
            exp_group.push_back(g[GRP_W-1:0]);
            exp_block.push_back(b[BLK_W-1:0]);
            exp_total.push_back(free_blocks[TOT_W-1:0]);
        endfunction

        // Work out the result of one accepted request beat.
        function void note_request(logic [GRP_W-1:0] start, logic [LEN_W-1:0] len);
            int unsigned best, best_dist, gdist, zeros, first;
            bit hit;
            hit = 0; best = 0; best_dist = 0; zeros = 0; first = 0;
            if (len == 0 || len > MAX_RUN) begin
                push(ST_NOSPACE, 0, 0);
                return;
            end
            for (int g = 0; g < GROUPS; g++) begin
                gdist = (g > start) ? g - start : start - g;
                if (grp_free[g] <= BLOCKS_PER_GROUP && grp_free[g] >= len &&
                    (!hit || gdist < best_dist)) begin
                    hit = 1; best = g; best_dist = gdist;
                end
            end
            if (!hit) begin
                push(ST_NOSPACE, 0, 0);
                return;
            end
            hit = 0;
            for (int b = 0; b < BLOCKS_PER_GROUP && !hit; b++) begin
                if (bitmap[best][b]) zeros = 0;
                else begin
                    zeros++;
                    if (zeros == len) begin
                        first = b + 1 - len;
                        hit = 1;
                    end
                end
            end
            if (!hit) begin
                push(ST_FRAG, 0, 0);
                return;
            end
            for (int b = 0; b < len; b++) bitmap[best][first + b] = 1'b1;
            grp_free[best] -= len;
            free_blocks = (free_blocks >= len) ? free_blocks - len : 0;
            push(ST_OK, best, first);
        endfunction

        // Compare one accepted result beat with the oldest expectation.
        function void check_result(logic [1:0] st, logic [GRP_W-1:0] g,
                                   logic [BLK_W-1:0] b, logic [TOT_W-1:0] t);
            status_t es;
            logic [GRP_W-1:0] eg;
            logic [BLK_W-1:0] eb;
            logic [TOT_W-1:0] et;
            if (exp_status.size() == 0) begin
                $display("%0t: unexpected result beat: got status %0d", $time, st);
                errors++;
                return;
            end
            es = exp_status.pop_front();
            eg = exp_group.pop_front();
            eb = exp_block.pop_front();
            et = exp_total.pop_front();
            case (es)
                ST_OK:      n_ok++;
                ST_NOSPACE: n_nospace++;
                default:    n_frag++;
            endcase
            if (st !== es) begin
                $display("%0t: status expected %0d actual %0d", $time, es, st);
                errors++;
            end
            if (g !== eg) begin
                $display("%0t: group_index expected %0d actual %0d", $time, eg, g);
                errors++;
            end
            if (b !== eb) begin
                $display("%0t: block_index expected %0d actual %0d", $time, eb, b);
                errors++;
            end
            if (t !== et) begin
                $display("%0t: total_free expected %0d actual %0d", $time, et, t);
                errors++;
            end
        endfunction
    endclass

    localparam int IDLE_LIMIT = 20000;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [GRP_W-1:0] s_start_group;
    logic [LEN_W-1:0] s_run_length;
    logic             m_valid;
    logic             m_ready;
    logic [1:0]       m_status;
    logic [GRP_W-1:0] m_group_index;
    logic [BLK_W-1:0] m_block_index;
    logic [TOT_W-1:0] m_total_free;

    alloc_scoreboard sb;
    int  n_sent;
    int  idle_cycles;
    bit  stall_mode;

    nearest_group_block_allocator_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_start_group (s_start_group),
        .s_run_length  (s_run_length),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_group_index (m_group_index),
        .m_block_index (m_block_index),
        .m_total_free  (m_total_free)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Check result beats, note request beats and run the watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_status, m_group_index, m_block_index, m_total_free);
            if (s_valid && s_ready) begin
                sb.note_request(s_start_group, s_run_length);
                n_sent++;
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: timeout, no beat for %0d cycles", $time, IDLE_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Receiver stalls: long ready stretches, then phases of random stalls.
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if (!stall_mode) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0) ? 1'b1 : ($urandom_range(0, 1) == 1);
    end

    always @(posedge aclk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    end

    // Present one request beat and hold it until it is accepted.
    task automatic send_request(input int unsigned start, input int unsigned len);
        s_valid       <= 1'b1;
        s_start_group <= start[GRP_W-1:0];
        s_run_length  <= len[LEN_W-1:0];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic sender_gap();
        int unsigned gap;
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.exp_status.size() != 0) @(posedge aclk);
    endtask

    // Random request at a random start group: mostly legal lengths, some zero or too long.
    task automatic send_random();
        int unsigned len;
        case ($urandom_range(0, 19))
            0:       len = 0;
            1:       len = $urandom_range(MAX_RUN + 1, 31);
            2, 3:    len = MAX_RUN;
            default: len = $urandom_range(1, MAX_RUN);
        endcase
        send_request($urandom_range(0, GROUPS - 1), len);
    endtask

    initial begin
        int burst;
        sb = new();
        sb.clear_state();
        n_sent        = 0;
        idle_cycles   = 0;
        stall_mode    = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_start_group = '0;
        s_run_length  = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed beats: field extremes and bad lengths.
        send_request(0, 1);
        send_request(15, 16);
        send_request(7, 0);
        send_request(7, 17);
        send_request(15, 31);
        send_request(5, 5);
        send_request(10, 1);
        send_request(0, 16);
        wait_drained();

        // Ask for runs of 16 at group 0 until it lacks room for one, so the nearest
        // neighbor takes the rest; then ask for a short run and for one at group 1.
        for (int i = 0; i < 64; i++) send_request(0, 16);
        send_request(0, 3);
        send_request(1, 16);
        wait_drained();

        // Random part, in bursts with gaps; pause for a full drain now and then.
        while (n_sent < 700) begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst; i++) send_random();
            sender_gap();
            if ($urandom_range(0, 15) == 0) wait_drained();
        end
        wait_drained();
        repeat (100) @(posedge aclk);

        $display("Sent %0d requests: %0d allocated, %0d no-space, %0d fragmented.",
                 n_sent, sb.n_ok, sb.n_nospace, sb.n_frag);
        if (sb.errors == 0 && sb.exp_status.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
